/* design/array_list_insert_delete_defines.svh */
// Assertion macros used by the checker of the array list block.
// Expects signals named clock and reset in the scope where a macro is used.
`ifndef ARRAY_LIST_INSERT_DELETE_DEFINES_SVH
`define ARRAY_LIST_INSERT_DELETE_DEFINES_SVH

// Checked only while reset is low.
`define ALID_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, including edges during reset.
`define ALID_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* design/alid_pkg.sv */
// Types and constants for the array list insert/delete block.
// No dependencies; imported by the top level, its checker and the testbench.
package alid_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int POS_W         = 5;
   localparam int VAL_W         = 32;
   localparam int COUNT_W       = 5;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   typedef struct packed {
      logic                    opcode;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                    ok;
      logic signed [VAL_W-1:0] removed_value;
      logic [COUNT_W-1:0]      count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_SHIFT,
      ST_INS_WR,
      ST_DEL_READ,
      ST_DEL_CAP,
      ST_DEL_SHIFT,
      ST_DEL_WR,
      ST_DONE
   } state_type;

endpackage

/* design/array_list_insert_delete.sv */
// Ordered list of up to DEPTH signed 32-bit entries held in a single memory,
// with insert and delete requests at 1-based positions. Depends on alid_pkg.
//
// One request is in work at a time: req_stall is high from the cycle after
// a request is taken until its response has been loaded into the output
// register. Entries move one at a time through the memory's single read and
// single write port. An insert at position p into a list of n entries moves
// n-p+1 entries, a delete moves n-p entries and a rejected request moves
// none. The output register lets a new request be taken while the previous
// response is still stalled.
// The memory needs no clearing after reset: only entries below the length
// are ever read.
module array_list_insert_delete #(
   parameter int DEPTH = alid_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  alid_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output alid_pkg::rsp_type rsp_data
);
   import alid_pkg::*;

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]        len_ff, len_in;
   logic [ADDR_W-1:0]       idx_ff, idx_in;
   logic [ADDR_W-1:0]       tgt_ff, tgt_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic signed [VAL_W-1:0] taken_ff, taken_in;
   logic                    ok_ff, ok_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic signed [VAL_W-1:0] entries_ff [DEPTH];
   logic signed [VAL_W-1:0] rd_data_ff;
   logic                    mem_we, mem_re;
   logic [ADDR_W-1:0]       mem_wa, mem_ra;
   logic signed [VAL_W-1:0] mem_wd;

   logic [CMP_W-1:0] len_cmp, pos_cmp, idx_cmp;
   logic             ins_ok, del_ok, rsp_free;

   assign len_cmp = CMP_W'(len_ff);
   assign pos_cmp = CMP_W'(req_data.position);
   assign idx_cmp = CMP_W'(idx_ff);

   assign ins_ok = (pos_cmp != '0) && (pos_cmp <= len_cmp + CMP_W'(1))
                   && (len_cmp < CMP_W'(DEPTH));
   assign del_ok = (pos_cmp != '0) && (pos_cmp <= len_cmp);

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      tgt_ff      <= tgt_in;
      val_ff      <= val_in;
      taken_ff    <= taken_in;
      ok_ff       <= ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entries_ff[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= entries_ff[mem_ra];
      end
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      tgt_in       = tgt_ff;
      val_in       = val_ff;
      taken_in     = taken_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_wa       = idx_ff;
      mem_ra       = idx_ff;
      mem_wd       = rd_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               val_in   = req_data.value;
               taken_in = '0;
               tgt_in   = ADDR_W'(pos_cmp - CMP_W'(1));
               if (req_data.opcode == OP_INSERT) begin
                  ok_in  = ins_ok;
                  idx_in = ADDR_W'(len_ff);
                  state_in = ins_ok ? ST_INS_SHIFT : ST_DONE;
               end else begin
                  ok_in  = del_ok;
                  idx_in = ADDR_W'(pos_cmp - CMP_W'(1));
                  state_in = del_ok ? ST_DEL_READ : ST_DONE;
               end
            end
         end
         // Walk down from the old end, copying each entry one place up,
         // until the target slot is reached; then drop the new value in.
         ST_INS_SHIFT: begin
            if (idx_ff == tgt_ff) begin
               mem_we   = 1'b1;
               mem_wd   = val_ff;
               len_in   = len_ff + CNT_W'(1);
               state_in = ST_DONE;
            end else begin
               mem_re   = 1'b1;
               mem_ra   = idx_ff - ADDR_W'(1);
               state_in = ST_INS_WR;
            end
         end
         ST_INS_WR: begin
            mem_we   = 1'b1;
            idx_in   = idx_ff - ADDR_W'(1);
            state_in = ST_INS_SHIFT;
         end
         ST_DEL_READ: begin
            mem_re   = 1'b1;
            state_in = ST_DEL_CAP;
         end
         ST_DEL_CAP: begin
            taken_in = rd_data_ff;
            state_in = ST_DEL_SHIFT;
         end
         // Pull each later entry one place down until the last one is moved.
         ST_DEL_SHIFT: begin
            if (idx_cmp + CMP_W'(1) == len_cmp) begin
               len_in   = len_ff - CNT_W'(1);
               state_in = ST_DONE;
            end else begin
               mem_re   = 1'b1;
               mem_ra   = idx_ff + ADDR_W'(1);
               state_in = ST_DEL_WR;
            end
         end
         ST_DEL_WR: begin
            mem_we   = 1'b1;
            idx_in   = idx_ff + ADDR_W'(1);
            state_in = ST_DEL_SHIFT;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.ok            = ok_ff;
               rsp_data_in.removed_value = taken_ff;
               rsp_data_in.count         = len_cmp[COUNT_W-1:0];
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* design/alid_checker.sv */
// Port-level checks for the array list insert/delete block, bound to its
// top level. Depends on alid_pkg and array_list_insert_delete_defines.svh.
`include "array_list_insert_delete_defines.svh"

module alid_checker #(
   parameter int DEPTH = alid_pkg::DEPTH_DEFAULT
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input alid_pkg::rsp_type rsp_data
);
   import alid_pkg::*;

   localparam int CHK_W = COUNT_W + 12;

   logic req_taken;
   logic [CHK_W-1:0] count_ext;

   assign req_taken = req_valid && !req_stall;
   assign count_ext = CHK_W'(rsp_data.count);

   // A response held by the receiver must not change.
   `ALID_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "response changed while stalled")
   // Reset leaves no response pending.
   `ALID_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "response valid right after reset")
   // Only one request is in work at a time.
   `ALID_ASSERT(a_busy_after_take, req_taken |=> req_stall, "second request taken while busy")
   // A failed request never reports a removed entry.
   `ALID_ASSERT(a_fail_zero, rsp_valid && !rsp_data.ok |-> rsp_data.removed_value == '0, "failed request returned a value")
   // The reported length stays within the capacity (checked when DEPTH is below 32).
   `ALID_ASSERT(a_count_range, rsp_valid && (DEPTH < 32) |-> count_ext <= CHK_W'(DEPTH), "count beyond capacity")

endmodule

bind array_list_insert_delete alid_checker #(.DEPTH(DEPTH)) u_alid_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the array list insert/delete block.
// Depends on alid_pkg and array_list_insert_delete; holds its own list predictor.
module tb_top;
   import alid_pkg::*;

   localparam int LIST_DEPTH  = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 1000000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Predicted list contents and length.
   logic signed [VAL_W-1:0] list_vals [LIST_DEPTH];
   int                      list_len;
   rsp_type                 pending_results [$];

   int mismatch_count = 0;
   int cycle_count = 0;
   bit idle_on;
   int gap_percent;
   int long_hold_left;
   int stall_burst_left = 0;
   int stall_quiet_left = 0;

   array_list_insert_delete #(.DEPTH(LIST_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL array_list_insert_delete");
         $finish;
      end
   end

   // Applies one request to the predicted list and returns the response it should give.
   function automatic rsp_type apply_list_op(req_type r);
      rsp_type res;
      int      pos;
      int      j;
      res = '0;
      pos = int'(r.position);
      if (r.opcode == OP_INSERT) begin
         if (pos >= 1 && pos <= list_len + 1 && list_len < LIST_DEPTH) begin
            for (j = list_len; j >= pos; j--)
               list_vals[j] = list_vals[j-1];
            list_vals[pos-1] = r.value;
            list_len++;
            res.ok = 1'b1;
         end
      end else if (pos >= 1 && pos <= list_len) begin
         res.removed_value = list_vals[pos-1];
         for (j = pos; j < list_len; j++)
            list_vals[j-1] = list_vals[j];
         list_len--;
         res.ok = 1'b1;
      end
      res.count = COUNT_W'(list_len);
      return res;
   endfunction

   function automatic req_type random_list_op(int insert_percent);
      req_type r;
      int      sel;
      r.opcode = ($urandom_range(0, 99) < insert_percent) ? OP_INSERT : OP_DELETE;
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
         if (r.opcode == OP_INSERT)
            r.position = POS_W'($urandom_range(1, list_len + 1));
         else
            r.position = POS_W'((list_len == 0) ? 1 : $urandom_range(1, list_len));
      end else if (sel < 86) begin
         r.position = '0;
      end else if (sel < 94) begin
         // Just past the end of the list.
         r.position = POS_W'((r.opcode == OP_INSERT) ? list_len + 2 : list_len + 1);
      end else begin
         r.position = POS_W'($urandom_range(0, 31));
      end
      case ($urandom_range(0, 19))
         0:       r.value = 32'h7FFF_FFFF;
         1:       r.value = 32'h8000_0000;
         2:       r.value = '0;
         3:       r.value = '1;
         default: r.value = $urandom;
      endcase
      return r;
   endfunction

   task automatic send_request(req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(apply_list_op(r));
   endtask

   task automatic sender_gap();
      int n;
      if (idle_on && gap_percent > 0 && $urandom_range(0, 99) < gap_percent) begin
         n = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_op(logic op, int pos, logic signed [VAL_W-1:0] val);
      req_type r;
      r.opcode   = op;
      r.position = POS_W'(pos);
      r.value    = val;
      send_request(r);
      sender_gap();
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic report_mismatch(string field, longint want, longint got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: response with nothing expected, expected none, %s",
                     $time, "actual:");
            $display("   ok=%0d removed=%0d count=%0d",
                     rsp_data.ok, rsp_data.removed_value, rsp_data.count);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.ok !== want.ok)
               report_mismatch("ok", want.ok, rsp_data.ok);
            if (rsp_data.removed_value !== want.removed_value)
               report_mismatch("removed_value", want.removed_value, rsp_data.removed_value);
            if (rsp_data.count !== want.count)
               report_mismatch("count", want.count, rsp_data.count);
         end
      end
   end

   // Response side: random stall bursts, quiet stretches, and a long hold-off on demand.
   always @(posedge clock) begin
      if (long_hold_left > 0) begin
         rsp_stall <= 1'b1;
         long_hold_left--;
      end else if (!idle_on) begin
         rsp_stall <= 1'b0;
      end else if (stall_burst_left > 0) begin
         rsp_stall <= 1'b1;
         stall_burst_left--;
      end else if (stall_quiet_left > 0) begin
         rsp_stall <= 1'b0;
         stall_quiet_left--;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_stall <= 1'b1;
         stall_burst_left = $urandom_range(0, 8);
      end else begin
         rsp_stall <= 1'b0;
         stall_quiet_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                        : $urandom_range(0, 12);
      end
   end

   task automatic test_directed();
      gap_percent = 30;
      // Deletes from an empty list all fail.
      send_op(OP_DELETE, 0, 0);
      send_op(OP_DELETE, 1, 0);
      send_op(OP_DELETE, 31, '1);
      send_op(OP_INSERT, 0, 5);
      send_op(OP_INSERT, 2, 6);
      send_op(OP_INSERT, 1, 32'h7FFF_FFFF);
      send_op(OP_INSERT, 1, 32'h8000_0000);
      send_op(OP_INSERT, 3, 0);
      send_op(OP_INSERT, 2, -1);
      repeat (12) send_op(OP_INSERT, $urandom_range(1, list_len + 1), $urandom);
      // The list is full now: even a position in range is refused.
      send_op(OP_INSERT, 5, 7);
      send_op(OP_INSERT, 17, 8);
      send_op(OP_DELETE, 17, 0);
      send_op(OP_DELETE, 16, 0);
      send_op(OP_DELETE, 1, 0);
      send_op(OP_DELETE, 7, 0);
      send_op(OP_DELETE, 0, 0);
      wait_for_results();
   endtask

   task automatic test_random_mix();
      int insert_pct [12] = '{75, 25, 90, 10, 50, 85, 15, 60, 95, 5, 55, 45};
      int phase;
      for (phase = 0; phase < 12; phase++) begin
         gap_percent = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         repeat (100) begin
            send_request(random_list_op(insert_pct[phase]));
            sender_gap();
         end
      end
      wait_for_results();
   endtask

   task automatic test_backpressure();
      gap_percent    = 0;
      long_hold_left = 300;
      repeat (30) send_request(random_list_op(60));
      wait_for_results();
   endtask

   task automatic test_no_idling();
      idle_on     = 1'b0;
      gap_percent = 0;
      repeat (4) begin
         repeat (50) send_request(random_list_op(80));
         repeat (50) send_request(random_list_op(30));
      end
      wait_for_results();
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      list_len         = 0;
      idle_on          = 1'b1;
      gap_percent      = 0;
      long_hold_left   = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_mix();
      test_backpressure();
      test_no_idling();

      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("PASS array_list_insert_delete");
      end else begin
         $display("FAIL array_list_insert_delete");
      end
      $finish;
   end

endmodule
